FILE: sv/binned_neutron_dose_accumulator_top_macros.svh
// Assertion macros shared by the dose accumulator modules.
// Every macro expects signals named clk and arst_n in the enclosing module.
`ifndef BINNED_NEUTRON_DOSE_ACCUMULATOR_TOP_MACROS_SVH
`define BINNED_NEUTRON_DOSE_ACCUMULATOR_TOP_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define BNDA_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that, when true, requires a second one in the same cycle.
`define BNDA_IMPLY(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

FILE: sv/bnda_pkg.sv
// Shared types, widths, bin edges and dose coefficients of the dose accumulator.
// No dependencies.
package bnda_pkg;

	localparam int NUM_BINS    = 33;
	localparam int EDGE_COUNT  = 34;
	localparam int ID_DEPTH    = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam int BIN_W    = 6;
	localparam int BIN_AW   = $clog2(NUM_BINS);
	localparam int ENERGY_W = 44;
	localparam int LEN_W    = 32;
	localparam int ID_W     = 32;
	localparam int ACC_W    = 48;
	localparam int DOSE_W   = 63;
	localparam int COUNT_W  = 32;
	localparam int COEFF_W  = 16;
	localparam int PROD_W   = COEFF_W + LEN_W;
	localparam int IDX_W    = $clog2(ID_DEPTH);
	localparam int FILL_W   = $clog2(ID_DEPTH + 1);

	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

	// Lower edges of the energy bins, in units of 1e-9 MeV.
	localparam logic [ENERGY_W-1:0] EDGES [EDGE_COUNT] = '{
		44'd1, 44'd10, 44'd100, 44'd1000, 44'd10000, 44'd100000, 44'd1000000,
		44'd10000000, 44'd100000000,
		44'd200000000, 44'd300000000, 44'd400000000, 44'd500000000,
		44'd600000000, 44'd700000000, 44'd800000000, 44'd900000000,
		44'd1000000000,
		44'd2000000000, 44'd3000000000, 44'd4000000000, 44'd5000000000,
		44'd6000000000, 44'd7000000000, 44'd8000000000, 44'd9000000000,
		44'd10000000000, 44'd20000000000, 44'd50000000000, 44'd100000000000,
		44'd200000000000, 44'd500000000000, 44'd1000000000000, 44'd5000000000000
	};

	// Fluence-to-dose coefficients per bin, scaled by one hundred.
	localparam logic [COEFF_W-1:0] COEFFS [NUM_BINS] = '{
		16'd673, 16'd730, 16'd852, 16'd992, 16'd1190, 16'd1890, 16'd5950,
		16'd10500, 16'd16500,
		16'd21000, 16'd23000, 16'd24000, 16'd24500, 16'd25000, 16'd25500,
		16'd26000, 16'd26500, 16'd27000, 16'd28500, 16'd30000, 16'd31000,
		16'd32000, 16'd33000, 16'd34000, 16'd35000, 16'd37500, 16'd38000,
		16'd39000, 16'd40000, 16'd41000, 16'd53000, 16'd58000, 16'd44000
	};

	typedef enum logic [1:0] {
		KIND_HIT   = 2'd0,
		KIND_EVENT = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	// One classified item as it waits between the front and back parts.
	typedef struct packed {
		kind_t              kind;
		logic               acc;
		logic [BIN_W-1:0]   bin;
		logic [LEN_W-1:0]   len;
		logic               stopped;
		logic [ID_W-1:0]    id;
	} entry_t;

	// The bin is the index of the highest edge not above the energy, clamped.
	function automatic logic [BIN_W-1:0] find_bin(input logic [ENERGY_W-1:0] e);
		logic [BIN_W-1:0] b;
		b = '0;
		for (int i = 0; i < EDGE_COUNT; i++) begin
			if (e >= EDGES[i]) begin
				b = BIN_W'(i);
			end
		end
		if (b > LAST_BIN) begin
			b = LAST_BIN;
		end
		return b;
	endfunction

endpackage

FILE: sv/bnda_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bnda_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/bnda_front.sv
// Front part: takes input items, decides whether a hit counts and finds its bin.
// Depends on bnda_pkg.
module bnda_front import bnda_pkg::*; (
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic                is_neutron,
	input  logic [ENERGY_W-1:0] energy,
	input  logic [LEN_W-1:0]    step_length,
	input  logic                stopped,
	input  logic [ID_W-1:0]     track_id,
	input  logic                q_full,
	output logic                push,
	output entry_t              push_data
);

	kind_t item_kind;

	assign item_kind = kind_t'(kind);
	assign in_stall  = q_full;
	assign push      = in_valid && !q_full;

	always_comb begin
		push_data.kind    = item_kind;
		push_data.acc     = (item_kind == KIND_HIT) && is_neutron && (step_length != '0);
		push_data.bin     = find_bin(energy);
		push_data.len     = step_length;
		push_data.stopped = stopped;
		push_data.id      = track_id;
	end

endmodule

FILE: sv/bnda_queue.sv
// Short queue of classified items between the front and back parts.
// Depends on bnda_pkg and the assertion macro header.
`include "binned_neutron_dose_accumulator_top_macros.svh"

module bnda_queue import bnda_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output logic   q_valid,
	output logic   q_full,
	output entry_t q_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_valid = (count_q != '0);
	assign q_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_data  = slots_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`BNDA_IMPLY(a_pop_not_empty, pop, count_q != '0, "queue popped while empty")

endmodule

FILE: sv/bnda_back.sv
// Back part: histogram, totals, dose and the per-event table of stopped tracks.
// Depends on bnda_pkg, bnda_ram and the assertion macro header.
`include "binned_neutron_dose_accumulator_top_macros.svh"

module bnda_back import bnda_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  entry_t              q_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                accepted,
	output logic [BIN_W-1:0]    energy_bin,
	output logic [ACC_W-1:0]    bin_track_length,
	output logic [ACC_W-1:0]    total_track_length,
	output logic [DOSE_W-1:0]   total_dose,
	output logic [COUNT_W-1:0]  absorption_count,
	output logic                id_table_overflow
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_ACC,
		S_SCAN,
		S_NEW,
		S_OUT
	} state_t;

	state_t              state_q;
	entry_t              ent_q;
	logic [NUM_BINS-1:0] vld_q;
	logic [ACC_W-1:0]    tot_q;
	logic [DOSE_W-1:0]   dose_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [FILL_W-1:0]   fill_q;
	logic [IDX_W-1:0]    idx_q;
	logic [PROD_W-1:0]   prod_q;

	logic                res_acc_q;
	logic [BIN_W-1:0]    res_bin_q;
	logic [ACC_W-1:0]    res_binlen_q;
	logic                res_ovf_q;

	logic                out_valid_q;
	logic                accepted_q;
	logic [BIN_W-1:0]    energy_bin_q;
	logic [ACC_W-1:0]    bin_len_q;
	logic [ACC_W-1:0]    tot_len_q;
	logic [DOSE_W-1:0]   dose_out_q;
	logic [COUNT_W-1:0]  count_out_q;
	logic                ovf_q;

	logic [ACC_W-1:0]    bin_rdata;
	logic [ACC_W-1:0]    old_binlen;
	logic [ACC_W:0]      bin_sum;
	logic [ACC_W:0]      tot_sum;
	logic [DOSE_W:0]     dose_sum;
	logic [ACC_W-1:0]    new_binlen;
	logic [ACC_W-1:0]    new_tot;
	logic [DOSE_W-1:0]   new_dose;
	logic                bin_we;

	logic [IDX_W-1:0]    id_raddr;
	logic [ID_W-1:0]     id_rdata;
	logic                id_we;
	logic                out_free;

	assign pop      = (state_q == S_IDLE) && q_valid;
	assign out_free = !out_valid_q || !out_stall;

	// A bin not written since the last clear reads as zero.
	assign old_binlen = vld_q[ent_q.bin] ? bin_rdata : '0;
	assign bin_sum    = {1'b0, old_binlen} + (ACC_W + 1)'(ent_q.len);
	assign tot_sum    = {1'b0, tot_q} + (ACC_W + 1)'(ent_q.len);
	assign dose_sum   = {1'b0, dose_q} + (DOSE_W + 1)'(prod_q);
	assign new_binlen = bin_sum[ACC_W] ? '1 : bin_sum[ACC_W-1:0];
	assign new_tot    = tot_sum[ACC_W] ? '1 : tot_sum[ACC_W-1:0];
	assign new_dose   = dose_sum[DOSE_W] ? '1 : dose_sum[DOSE_W-1:0];
	assign bin_we     = (state_q == S_ACC);

	// The scan reads entry zero while the histogram is updated, then one ahead.
	assign id_raddr = (state_q == S_SCAN) ? idx_q + 1'b1 : '0;
	assign id_we    = (state_q == S_NEW) && (fill_q < FILL_W'(ID_DEPTH));

	bnda_ram #(
		.WIDTH (ACC_W),
		.DEPTH (NUM_BINS)
	) u_bin_ram (
		.clk   (clk),
		.we    (bin_we),
		.waddr (BIN_AW'(ent_q.bin)),
		.wdata (new_binlen),
		.raddr (BIN_AW'(ent_q.bin)),
		.rdata (bin_rdata)
	);

	bnda_ram #(
		.WIDTH (ID_W),
		.DEPTH (ID_DEPTH)
	) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (fill_q[IDX_W-1:0]),
		.wdata (ent_q.id),
		.raddr (id_raddr),
		.rdata (id_rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= q_data;
		end
		if (state_q == S_EXEC) begin
			prod_q <= PROD_W'(COEFFS[ent_q.bin]) * PROD_W'(ent_q.len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			vld_q        <= '0;
			tot_q        <= '0;
			dose_q       <= '0;
			cnt_q        <= '0;
			fill_q       <= '0;
			idx_q        <= '0;
			res_acc_q    <= 1'b0;
			res_bin_q    <= '0;
			res_binlen_q <= '0;
			res_ovf_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			accepted_q   <= 1'b0;
			energy_bin_q <= '0;
			bin_len_q    <= '0;
			tot_len_q    <= '0;
			dose_out_q   <= '0;
			count_out_q  <= '0;
			ovf_q        <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_binlen_q <= '0;
					res_ovf_q    <= 1'b0;
					unique case (ent_q.kind)
						KIND_EVENT: begin
							fill_q <= '0;
						end
						KIND_CLEAR: begin
							vld_q  <= '0;
							tot_q  <= '0;
							dose_q <= '0;
							cnt_q  <= '0;
							fill_q <= '0;
						end
						default: begin
						end
					endcase
					// Only a counted hit carries the accept flag.
					if (ent_q.acc) begin
						res_acc_q <= 1'b1;
						res_bin_q <= ent_q.bin;
						state_q   <= S_ACC;
					end else begin
						res_acc_q <= 1'b0;
						res_bin_q <= '0;
						state_q   <= S_OUT;
					end
				end
				S_ACC: begin
					vld_q[ent_q.bin] <= 1'b1;
					tot_q            <= new_tot;
					dose_q           <= new_dose;
					res_binlen_q     <= new_binlen;
					if (!ent_q.stopped) begin
						state_q <= S_OUT;
					end else if (fill_q == '0) begin
						state_q <= S_NEW;
					end else begin
						idx_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (id_rdata == ent_q.id) begin
						state_q <= S_OUT;
					end else if (FILL_W'(idx_q) + 1'b1 == fill_q) begin
						state_q <= S_NEW;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_NEW: begin
					if (cnt_q != '1) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (fill_q < FILL_W'(ID_DEPTH)) begin
						fill_q <= fill_q + 1'b1;
					end else begin
						res_ovf_q <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						accepted_q   <= res_acc_q;
						energy_bin_q <= res_bin_q;
						bin_len_q    <= res_binlen_q;
						tot_len_q    <= tot_q;
						dose_out_q   <= dose_q;
						count_out_q  <= cnt_q;
						ovf_q        <= res_ovf_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign accepted           = accepted_q;
	assign energy_bin         = energy_bin_q;
	assign bin_track_length   = bin_len_q;
	assign total_track_length = tot_len_q;
	assign total_dose         = dose_out_q;
	assign absorption_count   = count_out_q;
	assign id_table_overflow  = ovf_q;

	`BNDA_CHECK(a_fill_bound, fill_q <= FILL_W'(ID_DEPTH), "track table fill beyond depth")
	`BNDA_IMPLY(a_scan_in_fill, state_q == S_SCAN, FILL_W'(idx_q) < fill_q, "scan past fill")
	`BNDA_IMPLY(a_ovf_needs_acc, out_valid_q && ovf_q, accepted_q, "overflow on uncounted item")
	`BNDA_IMPLY(a_bin_le_total, out_valid_q && accepted_q, bin_len_q <= tot_len_q, "bin above total")

endmodule

FILE: sv/binned_neutron_dose_accumulator_top.sv
// Neutron track length histogram with dose and stopped-track counting: top level.
// Depends on bnda_pkg, bnda_front, bnda_queue and bnda_back.
// Every item gives exactly one result. A counted hit passes through the back
// part in order (queue pop, histogram read and dose multiply, saturating update,
// result register); a rejected hit, an event start, a clear or an unused kind
// skips the update. A counted hit of a stopped track then searches the current
// event's track table of at most 64 identifiers, one entry a cycle through the
// table RAM's single read port. The front part classifies an item in the cycle
// it arrives and a two-entry queue holds items while the back part is busy; a
// finished result waits in the output register while the queue still takes up
// to two further items. No clearing pass follows reset.
module binned_neutron_dose_accumulator_top import bnda_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic                is_neutron,
	input  logic [ENERGY_W-1:0] energy,
	input  logic [LEN_W-1:0]    step_length,
	input  logic                stopped,
	input  logic [ID_W-1:0]     track_id,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                accepted,
	output logic [BIN_W-1:0]    energy_bin,
	output logic [ACC_W-1:0]    bin_track_length,
	output logic [ACC_W-1:0]    total_track_length,
	output logic [DOSE_W-1:0]   total_dose,
	output logic [COUNT_W-1:0]  absorption_count,
	output logic                id_table_overflow
);

	logic   push;
	entry_t push_data;
	logic   pop;
	logic   q_valid;
	logic   q_full;
	entry_t q_data;

	bnda_front u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.is_neutron  (is_neutron),
		.energy      (energy),
		.step_length (step_length),
		.stopped     (stopped),
		.track_id    (track_id),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data)
	);

	bnda_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_full    (q_full),
		.q_data    (q_data)
	);

	bnda_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.q_valid            (q_valid),
		.q_data             (q_data),
		.pop                (pop),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.accepted           (accepted),
		.energy_bin         (energy_bin),
		.bin_track_length   (bin_track_length),
		.total_track_length (total_track_length),
		.total_dose         (total_dose),
		.absorption_count   (absorption_count),
		.id_table_overflow  (id_table_overflow)
	);

endmodule
